>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> rtl/bht_pkg.sv
// Types and constants shared by the bucketed hash table modules.
package bht_pkg;

    localparam logic [1:0] CMD_SET = 2'd0;
    localparam logic [1:0] CMD_GET = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        HOP_HOLD,
        HOP_CLEAR,
        HOP_ADD,
        HOP_MIX,
        HOP_FIN1,
        HOP_FIN2
    } t_hop;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_MIX,
        S_FIN1,
        S_FIN2,
        S_MOD,
        S_LOOK,
        S_SCAN,
        S_DMOVE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [63:0] key;
        logic [3:0]  len;
        logic [31:0] hash;
        logic [31:0] value;
    } t_entry;

endpackage

>>> rtl/bht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bht_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bht_hash_unit.sv
// Shared one-at-a-time hash step unit with its hash accumulator register.
module bht_hash_unit
    import bht_pkg::*;
(
    input  logic        i_clk,
    input  t_hop        i_op,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_hash
);

    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic [31:0] sum;

    always_comb begin
        sum    = '0;
        n_hash = r_hash;
        case (i_op)
            HOP_CLEAR: begin
                n_hash = '0;
            end
            HOP_ADD: begin
                n_hash = r_hash + {{24{i_byte[7]}}, i_byte};
            end
            HOP_MIX: begin
                sum    = r_hash + (r_hash << 10);
                n_hash = sum ^ (sum >> 6);
            end
            HOP_FIN1: begin
                sum    = r_hash + (r_hash << 3);
                n_hash = sum ^ (sum >> 11);
            end
            HOP_FIN2: begin
                n_hash = r_hash + (r_hash << 15);
            end
            default: begin
                n_hash = r_hash;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
    end

    assign o_hash = r_hash;

endmodule

>>> rtl/bucketed_hash_table.sv
// Top level of the bucketed key/value table with one-at-a-time hashing.
// An item passes through the hash steps (add and mix per byte of the saturated key, then
// two finish steps), bucket select (bit-serial modulo when BUCKET_COUNT is not a power of
// two), lookup, a scan through the entry RAM read port, a move on delete, and the result.
// One item at a time: busy is high until the strobe cycle, start is taken the cycle after.
// Synchronous active-low reset empties every bucket through per-bucket valid bits.
module bucketed_hash_table
    import bht_pkg::*;
#(
    parameter int BUCKET_COUNT = 8,
    parameter int BUCKET_DEPTH = 16,
    parameter int KEY_BYTES    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_key_bytes,
    input  logic [3:0]  i_key_length,
    input  logic [31:0] i_value_in,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_value_out
);

    localparam int  BIW     = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int  FW      = $clog2(BUCKET_DEPTH + 1);
    localparam int  SLOTS   = BUCKET_COUNT * BUCKET_DEPTH;
    localparam int  AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int  EW      = $bits(t_entry);
    localparam bit  IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;

    t_state            r_state, n_state;
    logic [1:0]        r_cmd, n_cmd;
    logic [63:0]       r_key, n_key;
    logic [3:0]        r_len, n_len;
    logic [31:0]       r_vin, n_vin;
    logic [3:0]        r_byte, n_byte;
    logic [4:0]        r_bit, n_bit;
    logic [BIW-1:0]    r_bucket, n_bucket;
    logic [FW-1:0]     r_idx, n_idx;
    logic [FW-1:0]     r_found, n_found;
    t_status           r_status, n_status;
    logic [31:0]       r_value, n_value;
    logic [BUCKET_COUNT-1:0] r_fill_vld, n_fill_vld;

    t_hop              hop;
    logic [31:0]       hash;
    logic [3:0]        len_sat;
    logic [63:0]       key_trim;
    logic [BIW:0]      mod_t;
    logic [FW-1:0]     fill_rd;
    logic [FW-1:0]     fill;
    logic              fill_we;
    logic [FW-1:0]     fill_wdata;
    logic              ent_we;
    logic [AW-1:0]     ent_waddr;
    logic [AW-1:0]     ent_raddr;
    t_entry            ent_wdata;
    t_entry            ent_rd;
    logic [EW-1:0]     ent_rd_bits;
    logic              hit;

    bht_hash_unit u_hash (
        .i_clk  (i_clk),
        .i_op   (hop),
        .i_byte (r_key[8*r_byte[2:0] +: 8]),
        .o_hash (hash)
    );

    bht_ram #(
        .WIDTH  (EW),
        .DEPTH  (SLOTS),
        .ADDR_W (AW)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rd_bits)
    );

    bht_ram #(
        .WIDTH  (FW),
        .DEPTH  (BUCKET_COUNT),
        .ADDR_W (BIW)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (r_bucket),
        .i_wdata (fill_wdata),
        .i_raddr (r_bucket),
        .o_rdata (fill_rd)
    );

    assign ent_rd = t_entry'(ent_rd_bits);
    assign fill   = r_fill_vld[r_bucket] ? fill_rd : '0;
    assign hit    = (ent_rd.hash == hash) && (ent_rd.len == r_len) && (ent_rd.key == r_key);
    assign mod_t  = {r_bucket, hash[r_bit]};
    assign ent_raddr = AW'(32'(r_bucket) * BUCKET_DEPTH + 32'(n_idx));

    always_comb begin
        len_sat  = (i_key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_key_length;
        key_trim = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < len_sat) begin
                key_trim[8*b +: 8] = i_key_bytes[8*b +: 8];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_state = (r_byte == r_len) ? S_FIN1 : S_MIX;
            end
            S_MIX: begin
                n_state = S_ADD;
            end
            S_FIN1: begin
                n_state = S_FIN2;
            end
            S_FIN2: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                if (IS_POW2 || (r_bit == 5'd0)) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_cmd == CMD_GET || r_cmd == CMD_DEL) begin
                    if (r_idx >= fill) begin
                        n_state = S_RESP;
                    end else if (hit) begin
                        n_state = (r_cmd == CMD_DEL) ? S_DMOVE : S_RESP;
                    end
                end else begin
                    n_state = S_RESP;
                end
            end
            S_DMOVE: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        hop        = HOP_HOLD;
        fill_we    = 1'b0;
        fill_wdata = fill;
        ent_we     = 1'b0;
        ent_waddr  = AW'(32'(r_bucket) * BUCKET_DEPTH + 32'(fill));
        ent_wdata  = '{key: r_key, len: r_len, hash: hash, value: r_vin};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    hop = HOP_CLEAR;
                end
            end
            S_ADD: begin
                if (r_byte != r_len) begin
                    hop = HOP_ADD;
                end
            end
            S_MIX: begin
                hop = HOP_MIX;
            end
            S_FIN1: begin
                hop = HOP_FIN1;
            end
            S_FIN2: begin
                hop = HOP_FIN2;
            end
            S_SCAN: begin
                if (r_cmd == CMD_SET && fill < FW'(BUCKET_DEPTH)) begin
                    ent_we     = 1'b1;
                    fill_we    = 1'b1;
                    fill_wdata = fill + 1'b1;
                end
            end
            S_DMOVE: begin
                ent_waddr  = AW'(32'(r_bucket) * BUCKET_DEPTH + 32'(r_found));
                ent_wdata  = ent_rd;
                ent_we     = (r_found != r_idx);
                fill_we    = 1'b1;
                fill_wdata = fill - 1'b1;
            end
            default: begin
                hop = HOP_HOLD;
            end
        endcase
    end

    always_comb begin
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_len      = r_len;
        n_vin      = r_vin;
        n_byte     = r_byte;
        n_bit      = r_bit;
        n_bucket   = r_bucket;
        n_idx      = r_idx;
        n_found    = r_found;
        n_status   = r_status;
        n_value    = r_value;
        n_fill_vld = r_fill_vld;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = i_command;
                    n_key    = key_trim;
                    n_len    = len_sat;
                    n_vin    = i_value_in;
                    n_byte   = '0;
                    n_status = ST_DONE;
                    n_value  = '0;
                end
            end
            S_MIX: begin
                n_byte = r_byte + 4'd1;
            end
            S_FIN2: begin
                n_bucket = '0;
                n_bit    = 5'd31;
            end
            S_MOD: begin
                if (IS_POW2) begin
                    n_bucket = BIW'(hash & 32'(BUCKET_COUNT - 1));
                end else begin
                    n_bucket = (mod_t >= (BIW+1)'(BUCKET_COUNT))
                             ? BIW'(mod_t - (BIW+1)'(BUCKET_COUNT)) : BIW'(mod_t);
                    n_bit    = r_bit - 5'd1;
                end
            end
            S_LOOK: begin
                n_idx = '0;
            end
            S_SCAN: begin
                if (r_cmd == CMD_GET || r_cmd == CMD_DEL) begin
                    if (r_idx >= fill) begin
                        n_status = ST_MISSING;
                    end else if (hit) begin
                        n_value = ent_rd.value;
                        n_found = r_idx;
                        n_idx   = fill - 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else if (r_cmd == CMD_SET) begin
                    if (fill >= FW'(BUCKET_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_fill_vld[r_bucket] = 1'b1;
                    end
                end
            end
            default: begin
                n_cmd = r_cmd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill_vld <= '0;
        end else begin
            r_state    <= n_state;
            r_fill_vld <= n_fill_vld;
        end
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_len    <= n_len;
        r_vin    <= n_vin;
        r_byte   <= n_byte;
        r_bit    <= n_bit;
        r_bucket <= n_bucket;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_status <= n_status;
        r_value  <= n_value;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = (r_state == S_RESP);
    assign o_status    = r_status;
    assign o_value_out = r_value;

endmodule

>>> rtl/bht_checker.sv
// Port-level checker for the bucketed hash table and its bind statement.
`include "assert_macros.svh"

module bht_port_checker
    import bht_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic [31:0] o_value_out
);

    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    `ASSERT_CLK(a_strobe_single, i_clk, i_rst_n, o_strobe |=> !o_strobe)
    `ASSERT_CLK(a_strobe_in_busy, i_clk, i_rst_n, o_strobe |-> busy)
    `ASSERT_CLK(a_full_zero, i_clk, i_rst_n, (o_strobe && o_status == ST_FULL) |-> (o_value_out == '0))
    `ASSERT_CLK_NR(a_reset_idle, i_clk, !i_rst_n |=> (!busy && !o_strobe))

endmodule

bind bucketed_hash_table bht_port_checker u_bht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_status    (o_status),
    .o_value_out (o_value_out)
);
